// ===== rtl/core/lsd_decimal_radix_sorter_core_defines.svh =====
// Assertion macros for the checker of the radix sorter.
`ifndef LSD_DECIMAL_RADIX_SORTER_CORE_DEFINES_SVH
`define LSD_DECIMAL_RADIX_SORTER_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define LSD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked on every rising clock edge outside reset.
`define LSD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== rtl/core/lsdrs_pkg.sv =====
// Package with the constants and types of the radix sorter.
package lsdrs_pkg;
  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int DATA_W    = 32;
  localparam int RADIX     = 10;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DIG_W     = 4;
  localparam int NDIG      = 10;
  localparam int PASS_W    = 4;

  typedef struct packed {
    logic [DATA_W-1:0] key_value;
    logic              batch_end;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] sorted_value;
    logic              run_last;
    logic              overflow;
  } out_item_t;

  // 10^k for k = 0..9, as 32-bit constants.
  function automatic logic [31:0] pow10(input logic [PASS_W-1:0] k);
    logic [31:0] p;
    p = 32'd1;
    case (k)
      4'd0: p = 32'd1;
      4'd1: p = 32'd10;
      4'd2: p = 32'd100;
      4'd3: p = 32'd1000;
      4'd4: p = 32'd10000;
      4'd5: p = 32'd100000;
      4'd6: p = 32'd1000000;
      4'd7: p = 32'd10000000;
      4'd8: p = 32'd100000000;
      4'd9: p = 32'd1000000000;
      default: p = 32'd1;
    endcase
    return p;
  endfunction
endpackage

// ===== rtl/core/lsdrs_if.sv =====
// Valid/ready channel interfaces of the radix sorter.
interface lsdrs_in_if (input logic clk);
  import lsdrs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface lsdrs_out_if (input logic clk);
  import lsdrs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/lsd_decimal_radix_sorter_core.sv =====
// Top level of the base-10 LSD radix sorter.
//
//  channel | role   | payload                                  | handshake
//  in_     | sink   | key_value[31:0], batch_end               | valid/ready
//  out_    | source | sorted_value[31:0], run_last, overflow   | valid/ready
//
// Loading accepts one key transaction per cycle. After the closing key the block
// makes one pass per decimal digit of the largest key (up to ten, none when all
// keys are zero); each pass counts digits, forms prefix offsets and scatters
// between the two key memories, whose single read port sets the pace. Output
// then follows the last pass and is held by any stall on out_ready.
// Reset (rst_n low, synchronous) empties the batch; no memory clearing is needed.
// While sorting or emitting, in_ready is low; out stalls hold the output register.
module lsd_decimal_radix_sorter_core (
  input logic clk,
  input logic rst_n,
  lsdrs_in_if.sink    in_ch,
  lsdrs_out_if.source out_ch
);
  import lsdrs_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_COUNT = 3'd1;
  localparam logic [2:0] S_PREF  = 3'd2;
  localparam logic [2:0] S_SCAT  = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  // Reciprocal of ten: floor(x * RECIP10 / 2^RECIP_SH) equals x / 10 for any
  // 32-bit x.
  localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
  localparam int          RECIP_SH = 35;

  logic [2:0]           state_r;
  logic [CNT_W-1:0]     count_r;
  logic [DATA_W-1:0]    largest_r;
  logic                 dropped_r;
  logic [PASS_W-1:0]    pass_r;
  // Which memory holds the current keys: 0 = A, 1 = B.
  logic                 sel_r;
  logic [CNT_W-1:0]     rd_r;      // read address counter
  logic                 rv_r;      // registered read data valid
  logic [CNT_W-1:0]     bucket_r [NDIG];
  logic [DIG_W-1:0]     pi_r;
  logic [CNT_W-1:0]     sum_r;

  // Each memory word holds the key in its low half and, in its high half, the
  // key's quotient by the divisor of the pass that reads it next.
  logic                 a_we, b_we;
  logic [IDX_W-1:0]     a_wa, b_wa, raddr;
  logic [2*DATA_W-1:0]  a_wd, b_wd, a_rd, b_rd;
  logic [DATA_W-1:0]    rdat, qrd;

  lsdrs_ram #(.WIDTH(2*DATA_W), .DEPTH(CAPACITY)) u_ram_a (
    .clk(clk), .we(a_we), .waddr(a_wa), .wdata(a_wd), .raddr(raddr), .rdata(a_rd));
  lsdrs_ram #(.WIDTH(2*DATA_W), .DEPTH(CAPACITY)) u_ram_b (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(raddr), .rdata(b_rd));

  assign rdat = sel_r ? b_rd[DATA_W-1:0] : a_rd[DATA_W-1:0];
  assign qrd  = sel_r ? b_rd[2*DATA_W-1:DATA_W] : a_rd[2*DATA_W-1:DATA_W];

  logic [DATA_W-1:0] key_in;
  logic              in_acc, room;
  assign key_in = DATA_W'(in_ch.data.key_value[KEY_WIDTH-1:0]);
  assign room   = (count_r < CNT_W'(CAPACITY));
  assign in_ch.ready = (state_r == S_LOAD) && !out_ch.valid;
  assign in_acc = in_ch.valid && in_ch.ready;

  logic ovalid_r;
  out_item_t odata_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data  = odata_r;
  logic emit_go;
  assign emit_go = !ovalid_r || out_ch.ready;

  // While the output register is stalled the word in flight is read again, so
  // the registered read data still belongs to it when the stall ends.
  assign raddr = (state_r == S_EMIT && !emit_go && rv_r) ?
                 IDX_W'(rd_r - CNT_W'(1)) : rd_r[IDX_W-1:0];

  // Digit of the word in flight and its quotient by ten for the next pass.
  logic [2*DATA_W-1:0] qprod;
  logic [DATA_W-1:0]   q10;
  logic [DATA_W-1:0]   remw;
  logic [DIG_W-1:0]    dig;
  always_comb begin
    qprod = (2*DATA_W)'(qrd) * (2*DATA_W)'(RECIP10);
    q10   = DATA_W'(qprod >> RECIP_SH);
    remw  = qrd - ((q10 << 3) + (q10 << 1));
    dig   = remw[DIG_W-1:0];
  end

  logic [CNT_W-1:0] pos;
  assign pos = bucket_r[dig];
  // The pass just done was the last one once the largest key is below the
  // next power of ten, or after the tenth digit.
  logic last_pass;
  assign last_pass = (pass_r == PASS_W'(NDIG - 1)) ||
                     (largest_r < pow10(pass_r + PASS_W'(1)));

  always_comb begin
    a_we = 1'b0; b_we = 1'b0;
    a_wa = count_r[IDX_W-1:0]; b_wa = a_wa;
    a_wd = {key_in, key_in}; b_wd = a_wd;
    if (state_r == S_LOAD) begin
      a_we = in_acc && room;
    end else if (state_r == S_SCAT && rv_r) begin
      a_wa = pos[IDX_W-1:0]; b_wa = a_wa;
      a_wd = {q10, rdat}; b_wd = a_wd;
      a_we = sel_r; b_we = !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD; count_r <= '0; largest_r <= '0; dropped_r <= 1'b0;
      pass_r <= '0; sel_r <= 1'b0; rd_r <= '0; rv_r <= 1'b0; ovalid_r <= 1'b0;
      pi_r <= '0; sum_r <= '0;
      for (int d = 0; d < NDIG; d++) bucket_r[d] <= '0;
    end else begin
      unique case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count_r <= count_r + CNT_W'(1);
              if (key_in > largest_r) largest_r <= key_in;
            end else begin
              dropped_r <= 1'b1;
            end
            if (in_ch.data.batch_end) begin
              rd_r <= '0; rv_r <= 1'b0; pass_r <= '0; sel_r <= 1'b0;
              for (int d = 0; d < NDIG; d++) bucket_r[d] <= '0;
              if ((largest_r | (room ? key_in : '0)) == '0) state_r <= S_EMIT;
              else state_r <= S_COUNT;
            end
          end
        end
        S_COUNT: begin
          rv_r <= (rd_r < count_r);
          if (rd_r < count_r) rd_r <= rd_r + CNT_W'(1);
          if (rv_r) bucket_r[dig] <= bucket_r[dig] + CNT_W'(1);
          if (!(rd_r < count_r) && !rv_r) begin
            state_r <= S_PREF; pi_r <= '0; sum_r <= '0;
          end
        end
        S_PREF: begin
          bucket_r[pi_r] <= sum_r;
          sum_r <= sum_r + bucket_r[pi_r];
          if (pi_r == DIG_W'(NDIG - 1)) begin
            state_r <= S_SCAT; rd_r <= '0; rv_r <= 1'b0;
          end else begin
            pi_r <= pi_r + DIG_W'(1);
          end
        end
        S_SCAT: begin
          rv_r <= (rd_r < count_r);
          if (rd_r < count_r) rd_r <= rd_r + CNT_W'(1);
          if (rv_r) bucket_r[dig] <= pos + CNT_W'(1);
          if (!(rd_r < count_r) && !rv_r) begin
            sel_r <= !sel_r; rd_r <= '0;
            for (int d = 0; d < NDIG; d++) bucket_r[d] <= '0;
            if (last_pass) state_r <= S_EMIT;
            else begin
              pass_r <= pass_r + PASS_W'(1); state_r <= S_COUNT;
            end
          end
        end
        S_EMIT: begin
          if (ovalid_r && out_ch.ready) ovalid_r <= 1'b0;
          if (emit_go) begin
            rv_r <= (rd_r < count_r);
            if (rd_r < count_r) rd_r <= rd_r + CNT_W'(1);
            if (rv_r) begin
              ovalid_r <= 1'b1;
              odata_r.sorted_value <= rdat;
              odata_r.run_last <= (rd_r == count_r);
              odata_r.overflow <= dropped_r;
            end
            if (!(rd_r < count_r) && !rv_r) begin
              state_r <= S_LOAD; count_r <= '0; largest_r <= '0; dropped_r <= 1'b0;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end
endmodule

// ===== rtl/core/lsdrs_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
module lsdrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/core/lsdrs_checker.sv =====
// Port-level checker for the radix sorter, bound to the top level.
`include "lsd_decimal_radix_sorter_core_defines.svh"
module lsdrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_run_last
);
  logic last_acc;
  assign last_acc = out_valid && out_ready && out_run_last;

  `LSD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result lost")
  `LSD_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready, "input during output")
  `LSD_ASSERT_IMP(a_in_excl, clk, rst_n, in_valid && in_ready, !out_valid, "in/out overlap")
  `LSD_ASSERT_NXT(a_last_ends, clk, rst_n, last_acc, !out_valid, "extra result")
endmodule

bind lsd_decimal_radix_sorter_core lsdrs_checker u_chk (
  .clk(clk), .rst_n(rst_n),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_run_last(out_ch.data.run_last));
